// ===== design/ppm_ascii_pixmap_parser_top_assert.svh =====
// Assertion macros for the ASCII pixmap parser block.
// Used by the parser core and the result queue; empty under synthesis.
`ifndef PPM_ASCII_PIXMAP_PARSER_TOP_ASSERT_SVH
`define PPM_ASCII_PIXMAP_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define PPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define PPM_ASSERT(lbl, prop, msg)
`define PPM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/ppm_pkg.sv =====
// Shared types and codes for the ASCII pixmap parser.
// No dependencies.
`timescale 1ns / 1ps
package ppm_pkg;

    localparam logic [2:0] PH_MAGIC_P = 3'd0;
    localparam logic [2:0] PH_MAGIC_3 = 3'd1;
    localparam logic [2:0] PH_PARSE   = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_STOPPED = 3'd4;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_EOF    = 2'd3;

    localparam logic [1:0] ERR_MAGIC   = 2'd0;
    localparam logic [1:0] ERR_COMMENT = 2'd1;
    localparam logic [1:0] ERR_MAXVAL  = 2'd2;

    localparam logic [1:0] HDR_WIDTH   = 2'd0;
    localparam logic [1:0] HDR_HEIGHT  = 2'd1;
    localparam logic [1:0] HDR_MAXVAL  = 2'd2;
    localparam logic [1:0] HDR_SAMPLES = 2'd3;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_3    = 8'h33;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    localparam logic [15:0] ACC_MAX     = 16'hFFFF;
    localparam logic [15:0] MAXVAL_RST  = 16'd255;

    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  err;
        logic [15:0] img_w;
        logic [15:0] img_h;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] col;
        logic [15:0] row;
        logic        complete;
    } t_result;

    typedef struct packed {
        logic    res0_vld;
        t_result res0;
        logic    res1_vld;
        t_result res1;
    } t_push;

endpackage

// ===== design/ppm_parse.sv =====
// Parser core: header, comment and number state, one byte per transfer.
// Depends on ppm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ppm_ascii_pixmap_parser_top_assert.svh"
module ppm_core import ppm_pkg::*; #(
    parameter int DIM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_eof,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output t_push       o_push
);

    localparam logic [31:0] DIM_MAX = 32'((64'd1 << DIM_BITS) - 64'd1);

    logic [2:0]          r_phase,    n_phase;
    logic                r_in_comment, n_in_comment;
    logic                r_dseen,    n_dseen;
    logic [15:0]         r_acc,      n_acc;
    logic [1:0]          r_hdr_idx,  n_hdr_idx;
    logic [1:0]          r_chan,     n_chan;
    logic [DIM_BITS-1:0] r_width,    n_width;
    logic [DIM_BITS-1:0] r_height,   n_height;
    logic [DIM_BITS-1:0] r_col,      n_col;
    logic [DIM_BITS-1:0] r_row,      n_row;
    logic [7:0]          r_held_red, n_held_red;
    logic [7:0]          r_held_grn, n_held_grn;
    logic [15:0]         r_req_max;

    logic                is_digit, is_nl;
    logic [19:0]         acc10;
    logic [15:0]         acc_sat;
    logic                fin;
    logic                fin_dseen;
    logic [15:0]         fin_v;
    logic [DIM_BITS-1:0] v_dim;
    logic [DIM_BITS-1:0] col_inc, row_inc;
    t_result             res0, res1;
    logic                res0_vld;

    assign is_digit = (i_byte >= CHAR_0) && (i_byte <= CHAR_9);
    assign is_nl    = (i_byte == CHAR_CR) || (i_byte == CHAR_LF);
    assign acc10    = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {12'd0, i_byte - CHAR_0};
    assign acc_sat  = (acc10[19:16] != 4'd0) ? ACC_MAX : acc10[15:0];
    assign v_dim    = ({16'd0, fin_v} > DIM_MAX) ? DIM_BITS'(DIM_MAX) : DIM_BITS'(fin_v);
    assign col_inc  = r_col + 1'b1;
    assign row_inc  = r_row + 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_in_comment = r_in_comment;
        n_dseen      = r_dseen;
        n_acc        = r_acc;
        n_hdr_idx    = r_hdr_idx;
        n_chan       = r_chan;
        n_width      = r_width;
        n_height     = r_height;
        n_col        = r_col;
        n_row        = r_row;
        n_held_red   = r_held_red;
        n_held_grn   = r_held_grn;
        fin          = 1'b0;
        fin_dseen    = r_dseen;
        fin_v        = r_acc;
        res0         = '0;
        res0_vld     = 1'b0;
        res1         = '0;

        case (r_phase)
            PH_MAGIC_P: begin
                if (i_byte != CHAR_P) begin
                    n_phase  = PH_STOPPED;
                    res0_vld = 1'b1;
                    res0.kind = KIND_ERROR;
                    res0.err  = ERR_MAGIC;
                end else begin
                    n_phase = PH_MAGIC_3;
                end
            end
            PH_MAGIC_3: begin
                if (i_byte != CHAR_3) begin
                    n_phase  = PH_STOPPED;
                    res0_vld = 1'b1;
                    res0.kind = KIND_ERROR;
                    res0.err  = ERR_MAGIC;
                end else begin
                    n_phase = PH_PARSE;
                end
            end
            PH_PARSE: begin
                if (r_in_comment) begin
                    if (is_nl) begin
                        n_in_comment = 1'b0;
                        fin          = 1'b1;
                    end else if (i_eof) begin
                        res0_vld  = 1'b1;
                        res0.kind = KIND_ERROR;
                        res0.err  = ERR_COMMENT;
                    end
                end else if (i_byte == CHAR_HASH) begin
                    n_in_comment = 1'b1;
                    if (i_eof) begin
                        res0_vld  = 1'b1;
                        res0.kind = KIND_ERROR;
                        res0.err  = ERR_COMMENT;
                    end
                end else if (is_digit) begin
                    n_acc     = acc_sat;
                    n_dseen   = 1'b1;
                    fin       = i_eof;
                    fin_dseen = 1'b1;
                    fin_v     = acc_sat;
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // close a pending number
        if (fin && fin_dseen) begin
            n_dseen = 1'b0;
            n_acc   = '0;
            case (r_hdr_idx)
                HDR_WIDTH: begin
                    n_width   = v_dim;
                    n_hdr_idx = HDR_HEIGHT;
                end
                HDR_HEIGHT: begin
                    n_height  = v_dim;
                    n_hdr_idx = HDR_MAXVAL;
                end
                HDR_MAXVAL: begin
                    res0_vld = 1'b1;
                    if (fin_v != r_req_max) begin
                        n_phase   = PH_STOPPED;
                        res0.kind = KIND_ERROR;
                        res0.err  = ERR_MAXVAL;
                    end else begin
                        n_hdr_idx = HDR_SAMPLES;
                        res0.kind = KIND_HEADER;
                    end
                end
                default: begin
                    case (r_chan)
                        CH_RED: begin
                            n_held_red = fin_v[7:0];
                            n_chan     = CH_GREEN;
                        end
                        CH_GREEN: begin
                            n_held_grn = fin_v[7:0];
                            n_chan     = CH_BLUE;
                        end
                        default: begin
                            n_chan = CH_RED;
                            n_col  = col_inc;
                            if (col_inc >= r_width) begin
                                n_col = '0;
                                n_row = row_inc;
                                if (row_inc >= r_height) begin
                                    n_phase = PH_DONE;
                                end
                            end
                            res0_vld   = 1'b1;
                            res0.kind  = KIND_PIXEL;
                            res0.red   = r_held_red;
                            res0.green = r_held_grn;
                            res0.blue  = fin_v[7:0];
                            res0.col   = 16'(r_col);
                            res0.row   = 16'(r_row);
                        end
                    endcase
                end
            endcase
        end

        res0.img_w    = 16'(n_width);
        res0.img_h    = 16'(n_height);
        res0.complete = (n_phase == PH_DONE);
        res1.kind     = KIND_EOF;
        res1.img_w    = 16'(n_width);
        res1.img_h    = 16'(n_height);
        res1.complete = (n_phase == PH_DONE);

        if (i_eof) begin
            n_phase      = PH_MAGIC_P;
            n_in_comment = 1'b0;
            n_dseen      = 1'b0;
            n_acc        = '0;
            n_hdr_idx    = HDR_WIDTH;
            n_chan       = CH_RED;
            n_width      = '0;
            n_height     = '0;
            n_col        = '0;
            n_row        = '0;
            n_held_red   = '0;
            n_held_grn   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC_P;
            r_in_comment <= 1'b0;
            r_dseen      <= 1'b0;
            r_acc        <= '0;
            r_hdr_idx    <= HDR_WIDTH;
            r_chan       <= CH_RED;
            r_width      <= '0;
            r_height     <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_held_red   <= '0;
            r_held_grn   <= '0;
            r_req_max    <= MAXVAL_RST;
        end else begin
            if (i_cfg_we) begin
                r_req_max <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase      <= n_phase;
                r_in_comment <= n_in_comment;
                r_dseen      <= n_dseen;
                r_acc        <= n_acc;
                r_hdr_idx    <= n_hdr_idx;
                r_chan       <= n_chan;
                r_width      <= n_width;
                r_height     <= n_height;
                r_col        <= n_col;
                r_row        <= n_row;
                r_held_red   <= n_held_red;
                r_held_grn   <= n_held_grn;
            end
        end
    end

    assign o_push.res0_vld = i_accept && res0_vld;
    assign o_push.res0     = res0;
    assign o_push.res1_vld = i_accept && i_eof;
    assign o_push.res1     = res1;

    `PPM_ASSERT(a_eof_clears,
        i_accept && i_eof |=> r_phase == PH_MAGIC_P && !r_in_comment && !r_dseen,
        "state not cleared after end of file")
    `PPM_ASSERT(a_acc_idle, !r_dseen |-> r_acc == 16'd0,
        "accumulator nonzero without digits")
    `PPM_ASSERT(a_chan_hdr, r_hdr_idx != HDR_SAMPLES |-> r_chan == CH_RED,
        "channel advanced during header")
    `PPM_ASSERT(a_res1_eof, o_push.res1_vld |-> i_eof && o_push.res1.kind == KIND_EOF,
        "second result without end of file")

endmodule

// ===== design/ppm_res_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on ppm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ppm_ascii_pixmap_parser_top_assert.svh"
module ppm_res_fifo import ppm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop
);

    t_result           r_mem [RES_DEPTH];
    logic [RES_AW-1:0] r_wp, r_rp;
    logic [RES_AW:0]   r_cnt;
    logic [1:0]        push_n;
    logic              pop;
    t_result           first;

    assign push_n  = {1'b0, i_push.res0_vld} + {1'b0, i_push.res1_vld};
    assign first   = i_push.res0_vld ? i_push.res0 : i_push.res1;
    assign pop     = (r_cnt != '0) && i_pop;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_room  = r_cnt <= (RES_AW + 1)'(RES_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wp] <= first;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wp + 1'b1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RES_AW'(push_n);
            r_rp  <= r_rp + RES_AW'(pop);
            r_cnt <= r_cnt + (RES_AW + 1)'(push_n) - (RES_AW + 1)'(pop);
        end
    end

    `PPM_ASSERT(a_cnt_bound, r_cnt <= (RES_AW + 1)'(RES_DEPTH), "queue count beyond depth")
    `PPM_ASSERT(a_no_ovf, push_n != 2'd0 |-> o_room, "push into full queue")
    `PPM_ASSERT(a_ptr_match, r_cnt[RES_AW-1:0] == RES_AW'(r_wp - r_rp), "pointers disagree with count")

endmodule

// ===== design/ppm_ascii_pixmap_parser_top.sv =====
// Results are written to the result queue on the byte transfer and offered on the master side from it.
// Throughput: one byte per cycle while ready is high; the final byte makes an extra end result,
// drained through a four-entry result queue (ready drops while it holds three or more).
// Reset: synchronous active low; clears parser state and queue, max value back to 255.
// Top level of the ASCII pixmap parser; depends on ppm_pkg, ppm_core, ppm_res_fifo.
`timescale 1ns / 1ps
module ppm_ascii_pixmap_parser_top import ppm_pkg::*; #(
    parameter int DIM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // file_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // error_code[1:0], image_width[17:2], image_height[33:18], red[41:34],
    // green[49:42], blue[57:50], column[73:58], row[89:74], image_complete[90]
    output logic [95:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic    accept;
    t_push   push;
    t_result res;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    ppm_core #(
        .DIM_BITS (DIM_BITS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (s_axis_tdata),
        .i_eof      (s_axis_tlast),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_push     (push)
    );

    ppm_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (res),
        .i_pop   (m_axis_tready)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {5'd0, res.complete, res.row, res.col, res.blue, res.green,
                           res.red, res.img_h, res.img_w, res.err};

endmodule
